// ===== design/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared constants, payload types and round helpers for the pipelined cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    // Round structure: each round is two half-rounds, one pipeline stage each.
    localparam int ROUND_COUNT = 16;
    localparam int HALF_COUNT  = 2 * ROUND_COUNT;

    // Key schedule constant.
    localparam logic [31:0] DELTA = 32'h9e37_79b9;

    // Operation select carried in the request's tuser bit.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    // One block in flight through the pipeline.
    typedef struct packed {
        logic        op;
        logic [31:0] hi;
        logic [31:0] lo;
    } tea_item_t;

    // The 128-bit key as four words.
    typedef struct packed {
        logic [31:0] k3;
        logic [31:0] k2;
        logic [31:0] k1;
        logic [31:0] k0;
    } tea_key_t;

    // Mixing function of one half-round.
    function automatic logic [31:0] half_mix(input logic [31:0] x,
                                             input logic [31:0] sum,
                                             input logic [31:0] ka,
                                             input logic [31:0] kb);
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

    // Round sum seen by encrypt round rnd (counting from zero).
    function automatic logic [31:0] enc_sum(input int unsigned rnd);
        return 32'(DELTA * 32'(rnd + 1));
    endfunction

    // Round sum seen by decrypt round rnd (counting from zero).
    function automatic logic [31:0] dec_sum(input int unsigned rnd);
        return 32'(DELTA * 32'(ROUND_COUNT - rnd));
    endfunction

endpackage

// ===== design/tea_stage.sv =====
// ----------------------------------------------------------------------------
// TEA half-round stage
// One registered half-round. Encrypt and decrypt share the stage: the op bit
// of the item picks which word is updated, the key pair, the sum and whether
// the mix is added or subtracted.
// ----------------------------------------------------------------------------
module tea_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,     // whole pipeline moves this cycle
    input  logic              odd,         // second half of its round
    input  logic [31:0]       enc_sum,     // round sum for encrypt
    input  logic [31:0]       dec_sum,     // round sum for decrypt
    input  tea_pkg::tea_key_t key,
    input  logic              in_valid,
    input  tea_pkg::tea_item_t in_item,
    output logic              out_valid,
    output tea_pkg::tea_item_t out_item
);

    logic               valid_reg;
    logic               valid_next;
    tea_pkg::tea_item_t item_reg;
    tea_pkg::tea_item_t item_next;

    logic               upd_lo;
    logic [31:0]        src;
    logic [31:0]        dst;
    logic [31:0]        ka;
    logic [31:0]        kb;
    logic [31:0]        sum;
    logic [31:0]        mix;
    logic [31:0]        dst_new;

    // Encrypt updates the low word on even stages, decrypt on odd ones.
    always_comb
    begin
        upd_lo  = (in_item.op == odd);
        src     = upd_lo ? in_item.hi : in_item.lo;
        dst     = upd_lo ? in_item.lo : in_item.hi;
        ka      = upd_lo ? key.k0 : key.k2;
        kb      = upd_lo ? key.k1 : key.k3;
        sum     = (in_item.op == tea_pkg::OP_DECRYPT) ? dec_sum : enc_sum;
        mix     = tea_pkg::half_mix(src, sum, ka, kb);
        dst_new = (in_item.op == tea_pkg::OP_DECRYPT) ? (dst - mix) : (dst + mix);
    end

    // Next stage contents.
    always_comb
    begin
        item_next    = in_item;
        if (upd_lo)
        begin
            item_next.lo = dst_new;
        end
        else
        begin
            item_next.hi = dst_new;
        end
        valid_next   = advance ? in_valid : valid_reg;
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/tea_block_cipher_16_round.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher, 16 rounds
// Encrypts or decrypts one 64-bit block per cycle while the skid entry is free,
// through a 32-stage half-round pipeline, an output register and a skid entry.
// ----------------------------------------------------------------------------
// A result passes the 32 half-round stages and then the output register.
// Throughput: one block per cycle while the skid entry is free; 32 half-round
// stages, each one add, xor and add/subtract deep, set the latency.
// The input stalls only once the output is blocked and the skid entry fills.
// Reset clears all valid bits and sets the four key words to zero.
module tea_block_cipher_16_round (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] block_low, [63:32] block_high
    input  logic        s_axis_tuser,   // [0] op
    // Result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] result_low, [63:32] result_high
);

    localparam int HC = tea_pkg::HALF_COUNT;

    tea_pkg::tea_key_t  key_reg;
    tea_pkg::tea_key_t  key_next;

    logic [HC:0]        stage_valid;
    tea_pkg::tea_item_t stage_item [0:HC];
    logic               advance;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [63:0]        out_data_reg;
    logic [63:0]        out_data_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [63:0]        skid_data_reg;
    logic [63:0]        skid_data_next;
    logic               pop;
    logic               incoming;
    logic [63:0]        last_data;

    // Key register writes.
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tea_pkg::REG_KEY0: key_next.k0 = cfg_data;
                tea_pkg::REG_KEY1: key_next.k1 = cfg_data;
                tea_pkg::REG_KEY2: key_next.k2 = cfg_data;
                tea_pkg::REG_KEY3: key_next.k3 = cfg_data;
                default:           key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // The pipeline moves as long as the skid entry is free.
    assign advance       = !skid_valid_reg;
    assign s_axis_tready = advance;

    // Pipeline entry straight from the request.
    assign stage_valid[0]   = s_axis_tvalid;
    assign stage_item[0].op = s_axis_tuser;
    assign stage_item[0].lo = s_axis_tdata[31:0];
    assign stage_item[0].hi = s_axis_tdata[63:32];

    // Half-round stages.
    for (genvar s = 0; s < HC; s++)
    begin : g_stage
        tea_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .odd       (1'(s % 2)),
            .enc_sum   (tea_pkg::enc_sum(s / 2)),
            .dec_sum   (tea_pkg::dec_sum(s / 2)),
            .key       (key_reg),
            .in_valid  (stage_valid[s]),
            .in_item   (stage_item[s]),
            .out_valid (stage_valid[s + 1]),
            .out_item  (stage_item[s + 1])
        );
    end

    // Output register and skid entry.
    always_comb
    begin
        pop             = out_valid_reg && m_axis_tready;
        incoming        = advance && stage_valid[HC];
        last_data       = {stage_item[HC].hi, stage_item[HC].lo};
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (incoming)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = last_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = last_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // The skid entry only holds a result behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // The skid entry fills only when the output was blocked.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid entry filled without an output stall");

    // While the skid entry is full the pipeline holds still.
    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(stage_valid[HC:1]))
        else $error("pipeline moved while skid entry was full");
`endif

endmodule
